// File: design/dfi_pkg.sv
`timescale 1ns / 1ps
// Package for the direct form I IIR filter: sizes, register indexes and
// the command/status structs between controller and datapath. No dependencies.
package dfi_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int COEF_W          = 16;
   localparam int FF_TAPS         = 3;
   localparam int FB_TAPS         = 2;
   localparam int COEFF_FRAC_BITS = 14;

   localparam int NUM_TAPS = FF_TAPS + FB_TAPS;
   localparam int TAP_W    = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int ACC_W    = PROD_W + $clog2(NUM_TAPS + 1);
   localparam int SHIFT_W  = ACC_W - COEFF_FRAC_BITS;

   // configuration register map
   localparam int NUM_REGS    = 5;
   localparam int FF_REGS     = 3;
   localparam int FB_REGS     = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_FF_COEFF_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FF_COEFF_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FF_COEFF_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FB_COEFF_1 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FB_COEFF_2 = 3'd4;

   localparam logic signed [COEF_W-1:0] FF_COEFF_0_RESET = 16'sd16384;

   typedef logic [TAP_W-1:0] tap_type;

   typedef struct packed {
      logic    load;    // capture new sample, clear accumulator
      logic    mul;     // multiply tap
      logic    acc;     // add registered product
      logic    finish;  // shift, saturate, write result, shift histories
      tap_type tap;
   } cmd_type;

   typedef struct packed {
      logic out_full;
   } sts_type;

endpackage

// File: design/dfi_req_if.sv
`timescale 1ns / 1ps
// Input sample channel of the IIR filter.
// Depends on dfi_pkg for the sample width.
interface dfi_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [dfi_pkg::SAMPLE_W-1:0]   sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

// File: design/dfi_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the IIR filter: filtered sample and clip flag.
// Depends on dfi_pkg for the sample width.
interface dfi_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [dfi_pkg::SAMPLE_W-1:0]   sample_out;
   logic                                  clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// File: design/direct_form_iir_filter.sv
`timescale 1ns / 1ps
// Top level of the direct form I IIR filter: controller plus datapath.
// Depends on dfi_pkg, dfi_req_if, dfi_rsp_if, dfi_ctrl, dfi_datapath.
//
//   channel   direction  handshake       payload
//   req_ch    in         valid/ready     sample_in (s16)
//   rsp_ch    out        valid/ready     sample_out (s16), clipped
//   csr_*     in         write enable    csr_index (3), csr_write_data (16)
//
// Each sample steps through an accept step, one multiply step per tap on the
// single shared multiplier (five taps), one drain add and one finish step.
// A new sample is taken while the previous result waits in the output register;
// a stalled result holds the finish step until it is taken.
// Synchronous reset loads the default coefficients and clears both histories.
module direct_form_iir_filter (
   input  logic                              clock,
   input  logic                              reset,
   dfi_req_if.sink                           req_ch,
   dfi_rsp_if.source                         rsp_ch,
   input  logic                              csr_write_en,
   input  logic [dfi_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dfi_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   dfi_pkg::cmd_type cmd;
   dfi_pkg::sts_type sts;
   logic             ready;

   assign req_ch.ready = ready;

   dfi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dfi_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .sample_in      (req_ch.sample_in),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_ch         (rsp_ch)
   );

endmodule

// File: design/dfi_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the IIR filter: walks the shared multiplier over the taps.
// Depends on dfi_pkg for the command and status structs.
module dfi_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dfi_pkg::sts_type sts,
   output dfi_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MUL    = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   localparam dfi_pkg::tap_type LAST_TAP = dfi_pkg::TAP_W'(dfi_pkg::NUM_TAPS - 1);

   logic [1:0]       state_ff, state_in;
   dfi_pkg::tap_type tap_ff, tap_in;
   logic             accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   always_comb begin
      state_in   = state_ff;
      tap_in     = tap_ff;
      cmd        = '0;
      cmd.tap    = tap_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               tap_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            cmd.acc = (tap_ff != '0);
            if (tap_ff == LAST_TAP) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            cmd.acc  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold here while the previous result is still waiting
            if (!sts.out_full) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !sts.out_full)
      else $error("finish issued while output register full");

   a_last_tap_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && tap_ff == LAST_TAP) |=> (state_ff == ST_DRAIN))
      else $error("last tap did not move to drain");

   a_accept_starts_mac: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MUL && tap_ff == '0))
      else $error("accepted transaction did not start at tap zero");

   a_no_mul_and_finish: assert property (@(posedge clock) disable iff (reset)
      !(cmd.mul && cmd.finish) && !(cmd.load && cmd.acc))
      else $error("conflicting datapath commands");
`endif

endmodule

// File: design/dfi_datapath.sv
`timescale 1ns / 1ps
// Datapath of the IIR filter: coefficients, histories, shared multiplier,
// accumulator, shift/saturate and output register. Depends on dfi_pkg, dfi_rsp_if.
module dfi_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [dfi_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [dfi_pkg::CSR_DATA_W-1:0]        csr_write_data,
   input  logic signed [dfi_pkg::SAMPLE_W-1:0]   sample_in,
   input  dfi_pkg::cmd_type                      cmd,
   output dfi_pkg::sts_type                      sts,
   dfi_rsp_if.source                             rsp_ch
);

   localparam int SW = dfi_pkg::SAMPLE_W;

   logic signed [dfi_pkg::COEF_W-1:0] coef_ff [dfi_pkg::NUM_TAPS];
   logic signed [SW-1:0]              in_hist_ff  [dfi_pkg::FF_TAPS-1];
   logic signed [SW-1:0]              out_hist_ff [dfi_pkg::FB_TAPS];
   logic signed [SW-1:0]              x_ff;
   logic signed [dfi_pkg::PROD_W-1:0] prod_ff;
   logic signed [dfi_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [SW-1:0]              operand [dfi_pkg::NUM_TAPS];
   logic signed [dfi_pkg::SHIFT_W-1:0] shifted;
   logic signed [SW-1:0]              y_sat;
   logic                              clip;
   logic                              out_valid_ff;
   logic signed [SW-1:0]              out_sample_ff;
   logic                              out_clip_ff;
   logic [dfi_pkg::CSR_INDEX_W-1:0]   fb_k;

   // operand per tap: current sample, input history, output history
   always_comb begin
      operand[0] = x_ff;
      for (int i = 1; i < dfi_pkg::FF_TAPS; i++) begin
         operand[i] = in_hist_ff[i-1];
      end
      for (int i = 0; i < dfi_pkg::FB_TAPS; i++) begin
         operand[dfi_pkg::FF_TAPS + i] = out_hist_ff[i];
      end
   end

   assign acc_in = acc_ff + {{(dfi_pkg::ACC_W - dfi_pkg::PROD_W){prod_ff[dfi_pkg::PROD_W-1]}},
                             prod_ff};

   // arithmetic shift floors; clip when the upper bits are not a sign extension
   assign shifted = dfi_pkg::SHIFT_W'(acc_ff >>> dfi_pkg::COEFF_FRAC_BITS);
   assign clip    = (shifted[dfi_pkg::SHIFT_W-1:SW-1] != {(dfi_pkg::SHIFT_W-SW+1){1'b0}}) &&
                    (shifted[dfi_pkg::SHIFT_W-1:SW-1] != {(dfi_pkg::SHIFT_W-SW+1){1'b1}});
   always_comb begin
      if (!clip) begin
         y_sat = shifted[SW-1:0];
      end else if (shifted[dfi_pkg::SHIFT_W-1]) begin
         y_sat = {1'b1, {(SW-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(SW-1){1'b1}}};
      end
   end

   assign fb_k = csr_index - dfi_pkg::REG_FB_COEFF_1;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dfi_pkg::NUM_TAPS; i++) begin
            coef_ff[i] <= '0;
         end
         coef_ff[0] <= dfi_pkg::FF_COEFF_0_RESET;
      end else if (csr_write_en) begin
         if (csr_index < dfi_pkg::REG_FB_COEFF_1) begin
            if (32'(csr_index) < dfi_pkg::FF_TAPS) begin
               coef_ff[dfi_pkg::TAP_W'(csr_index)] <= csr_write_data;
            end
         end else if (32'(fb_k) < dfi_pkg::FB_REGS && 32'(fb_k) < dfi_pkg::FB_TAPS) begin
            coef_ff[dfi_pkg::TAP_W'(32'(fb_k) + dfi_pkg::FF_TAPS)] <= csr_write_data;
         end
      end
   end

   // histories
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dfi_pkg::FF_TAPS - 1; i++) begin
            in_hist_ff[i] <= '0;
         end
         for (int i = 0; i < dfi_pkg::FB_TAPS; i++) begin
            out_hist_ff[i] <= '0;
         end
      end else if (cmd.finish) begin
         in_hist_ff[0] <= x_ff;
         for (int i = 1; i < dfi_pkg::FF_TAPS - 1; i++) begin
            in_hist_ff[i] <= in_hist_ff[i-1];
         end
         out_hist_ff[0] <= y_sat;
         for (int i = 1; i < dfi_pkg::FB_TAPS; i++) begin
            out_hist_ff[i] <= out_hist_ff[i-1];
         end
      end
   end

   // multiply-accumulate payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff   <= sample_in;
         acc_ff <= '0;
      end else if (cmd.acc) begin
         acc_ff <= acc_in;
      end
      if (cmd.mul) begin
         prod_ff <= coef_ff[cmd.tap] * operand[cmd.tap];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_sample_ff <= y_sat;
         out_clip_ff   <= clip;
      end
   end

   assign sts.out_full      = out_valid_ff;
   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.sample_out = out_sample_ff;
   assign rsp_ch.clipped    = out_clip_ff;

`ifndef NO_ASSERTIONS
   a_valid_rises_on_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(cmd.finish))
      else $error("result valid without finish");

   a_result_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ch.ready) |=> ($stable(out_sample_ff) && $stable(out_clip_ff)))
      else $error("stalled result changed");

   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && clip) |=>
         (out_sample_ff == {out_sample_ff[SW-1], {(SW-1){!out_sample_ff[SW-1]}}}))
      else $error("clipped result is not a rail value");
`endif

endmodule
